FILE: hdl/slsm_pkg.sv
// Shared package for the sorted list set merge block.
// Holds list sizing, command and operation codes, and the control/status types.
// No dependencies.
`timescale 1ns / 1ps

package slsm_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int ID_W       = 31;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [1:0] CMD_RUN           = 2'd2;

    localparam logic [1:0] OP_INTERSECT = 2'd0;
    localparam logic [1:0] OP_UNION     = 2'd1;
    localparam logic [1:0] OP_DIFF      = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hdl/slsm_ctrl.sv
// Controller state machine for the sorted list set merge block.
// Sequences appends, the merge walk and the closing item; depends on slsm_pkg.
`timescale 1ns / 1ps

module slsm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [1:0]          cmd,
    output logic                req_stall,
    input  slsm_pkg::dp_status_t status,
    output slsm_pkg::dp_cmd_t   dp_cmd
);
    import slsm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                dp_cmd.load = accept;
                if (accept && cmd == CMD_RUN)
                begin
                    dp_cmd.start = 1'b1;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK:
            begin
                dp_cmd.step = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // The last item (or the empty marker) needs a free output slot.
                dp_cmd.finish = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/slsm_dp.sv
// Datapath for the sorted list set merge block: the two list memories, counts,
// walk pointers, the held-back last id and the output register; uses slsm_pkg.
`timescale 1ns / 1ps

module slsm_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  slsm_pkg::dp_cmd_t              dp_cmd,
    output slsm_pkg::dp_status_t           status,
    input  logic [1:0]                     cmd,
    input  logic [slsm_pkg::ID_W-1:0]      doc_id,
    input  logic [1:0]                     set_op,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [slsm_pkg::ID_W-1:0]      result_id,
    output logic                           is_last,
    output logic                           is_empty,
    output logic                           overflowed
);
    import slsm_pkg::*;

    logic [ID_W-1:0]  first_mem  [LIST_DEPTH];
    logic [ID_W-1:0]  second_mem [LIST_DEPTH];

    logic [CNT_W-1:0] first_cnt_reg;
    logic [CNT_W-1:0] first_cnt_next;
    logic [CNT_W-1:0] second_cnt_reg;
    logic [CNT_W-1:0] second_cnt_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [1:0]       op_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] i_next;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] j_next;
    logic [ID_W-1:0]  a_reg;
    logic [ID_W-1:0]  b_reg;
    logic             pend_valid_reg;
    logic [ID_W-1:0]  pend_id_reg;
    logic             out_valid_reg;
    logic [ID_W-1:0]  out_id_reg;
    logic             out_last_reg;
    logic             out_empty_reg;
    logic             out_ovf_reg;

    logic             a_ok;
    logic             b_ok;
    logic             take_both;
    logic             take_first;
    logic             take_second;
    logic             emit;
    logic [ID_W-1:0]  emit_id;
    logic             adv_i;
    logic             adv_j;
    logic             out_free;
    logic             step_go;
    logic             push_mid;
    logic             wr_first;
    logic             wr_second;

    assign a_ok     = (i_reg < first_cnt_reg);
    assign b_ok     = (j_reg < second_cnt_reg);
    assign out_free = !out_valid_reg || !rsp_stall;

    assign status.walk_done = !a_ok && !b_ok;
    assign status.out_free  = out_free;

    always_comb
    begin
        take_both   = 1'b0;
        take_first  = 1'b0;
        take_second = 1'b0;
        case (op_reg)
            OP_INTERSECT:
            begin
                take_both = 1'b1;
            end
            OP_UNION:
            begin
                take_both   = 1'b1;
                take_first  = 1'b1;
                take_second = 1'b1;
            end
            OP_DIFF:
            begin
                take_first = 1'b1;
            end
            default:
            begin
                take_both = 1'b0;
            end
        endcase
    end

    // One step of the two-pointer walk on the current list heads.
    always_comb
    begin
        emit    = 1'b0;
        emit_id = a_reg;
        adv_i   = 1'b0;
        adv_j   = 1'b0;
        if (a_ok && b_ok)
        begin
            if (a_reg == b_reg)
            begin
                emit  = take_both;
                adv_i = 1'b1;
                adv_j = 1'b1;
            end
            else if (a_reg < b_reg)
            begin
                emit  = take_first;
                adv_i = 1'b1;
            end
            else
            begin
                emit    = take_second;
                emit_id = b_reg;
                adv_j   = 1'b1;
            end
        end
        else if (a_ok)
        begin
            emit  = take_first;
            adv_i = 1'b1;
        end
        else if (b_ok)
        begin
            emit    = take_second;
            emit_id = b_reg;
            adv_j   = 1'b1;
        end
    end

    // A new id pushes the held one out, so the step waits for a free output slot.
    assign step_go  = dp_cmd.step && !(emit && pend_valid_reg && !out_free);
    assign push_mid = step_go && emit && pend_valid_reg;

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (dp_cmd.start)
        begin
            i_next = '0;
            j_next = '0;
        end
        else if (step_go)
        begin
            if (adv_i)
            begin
                i_next = i_reg + CNT_W'(1);
            end
            if (adv_j)
            begin
                j_next = j_reg + CNT_W'(1);
            end
        end
    end

    assign wr_first  = dp_cmd.load && (cmd == CMD_APPEND_FIRST)
                       && (first_cnt_reg < CNT_W'(LIST_DEPTH));
    assign wr_second = dp_cmd.load && (cmd == CMD_APPEND_SECOND)
                       && (second_cnt_reg < CNT_W'(LIST_DEPTH));

    always_comb
    begin
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        ovf_next        = ovf_reg;
        if (dp_cmd.finish)
        begin
            first_cnt_next  = '0;
            second_cnt_next = '0;
            ovf_next        = 1'b0;
        end
        else if (dp_cmd.load)
        begin
            if (wr_first)
            begin
                first_cnt_next = first_cnt_reg + CNT_W'(1);
            end
            if (wr_second)
            begin
                second_cnt_next = second_cnt_reg + CNT_W'(1);
            end
            if ((cmd == CMD_APPEND_FIRST && !wr_first)
                || (cmd == CMD_APPEND_SECOND && !wr_second))
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // List memories; read data follows the next pointer so heads are ready each cycle.
    always_ff @(posedge clk)
    begin
        if (wr_first)
        begin
            first_mem[first_cnt_reg[ADDR_W-1:0]] <= doc_id;
        end
        if (wr_second)
        begin
            second_mem[second_cnt_reg[ADDR_W-1:0]] <= doc_id;
        end
        a_reg <= first_mem[i_next[ADDR_W-1:0]];
        b_reg <= second_mem[j_next[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            ovf_reg        <= ovf_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            if (dp_cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (step_go && emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (push_mid || dp_cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.start)
        begin
            op_reg <= set_op;
        end
        if (step_go && emit)
        begin
            pend_id_reg <= emit_id;
        end
        if (push_mid)
        begin
            out_id_reg    <= pend_id_reg;
            out_last_reg  <= 1'b0;
            out_empty_reg <= 1'b0;
            out_ovf_reg   <= ovf_reg;
        end
        else if (dp_cmd.finish)
        begin
            out_id_reg    <= pend_valid_reg ? pend_id_reg : '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= !pend_valid_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign result_id  = out_id_reg;
    assign is_last    = out_last_reg;
    assign is_empty   = out_empty_reg;
    assign overflowed = out_ovf_reg;

endmodule

FILE: hdl/sorted_list_set_merge_core.sv
// Top level of the sorted list set merge block.
// Joins the controller (slsm_ctrl) and the datapath (slsm_dp); uses slsm_pkg.
`timescale 1ns / 1ps

// Appends (cmd 0 and 1) are taken one per cycle while the block is idle; an
// append to a full list is dropped and sets the overflow flag. A run (cmd 2)
// holds off requests while the merge walks both lists with one list-head
// comparison per cycle while no result waits on a stalled output; each walk
// step advances past one list head, or past both when the heads are equal.
// The controller then sees the walk end and, once the output register is
// free, loads the final item. Each list memory has one read port whose
// registered data follows the walk pointer, which sets the one-compare-
// per-cycle pace. Result transfers come from an output register, and the
// final item carries is_last, or is_empty with a zero id when nothing matched.
module sorted_list_set_merge_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [1:0]                cmd,
    input  logic [slsm_pkg::ID_W-1:0] doc_id,
    input  logic [1:0]                set_op,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [slsm_pkg::ID_W-1:0] result_id,
    output logic                      is_last,
    output logic                      is_empty,
    output logic                      overflowed
);
    import slsm_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t status;

    slsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .cmd       (cmd),
        .req_stall (req_stall),
        .status    (status),
        .dp_cmd    (dp_cmd)
    );

    slsm_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .status     (status),
        .cmd        (cmd),
        .doc_id     (doc_id),
        .set_op     (set_op),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .result_id  (result_id),
        .is_last    (is_last),
        .is_empty   (is_empty),
        .overflowed (overflowed)
    );

endmodule

FILE: hdl/slsm_checker.sv
// Port-level checker for the sorted list set merge block, bound to the top level.
// Uses slsm_pkg for widths and command codes.
`timescale 1ns / 1ps

module slsm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_stall,
    input logic [1:0]                cmd,
    input logic [slsm_pkg::ID_W-1:0] doc_id,
    input logic [1:0]                set_op,
    input logic                      rsp_valid,
    input logic                      rsp_stall,
    input logic [slsm_pkg::ID_W-1:0] result_id,
    input logic                      is_last,
    input logic                      is_empty,
    input logic                      overflowed
);
    import slsm_pkg::*;

    // A stalled result transfer keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(result_id)
            && $stable(is_last) && $stable(is_empty) && $stable(overflowed))
        else $error("result payload changed while stalled");

    // The empty marker is always the final item and carries a zero id.
    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_empty |-> is_last && result_id == '0)
        else $error("empty item not marked last or id nonzero");

    // Appends never hold off the next request.
    a_append_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && cmd != CMD_RUN |=> !req_stall)
        else $error("request stalled after an append");

    // A run always holds off requests while it walks.
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && cmd == CMD_RUN |=> req_stall)
        else $error("request taken during a run");

endmodule

bind sorted_list_set_merge_core slsm_checker u_slsm_checker (.*);
